// ===== sv/stsc_pkg.sv =====
// Shared types, constants and helper functions for the source text statistics counter.
// Has no dependencies; every other file refers to it by scoped names.
`default_nettype none

package stsc_pkg;

    // Counter width, output field width and code point width
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CP_WIDTH    = 21;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CP_WIDTH-1:0]    code_point_t;
    typedef logic [OUT_WIDTH-1:0]   out_count_t;

    localparam count_t CNT_MAX = '1;

    // Character codes that get special treatment
    localparam code_point_t CP_CR    = 21'h00000D;
    localparam code_point_t CP_LF    = 21'h00000A;
    localparam code_point_t CP_TAB   = 21'h000009;
    localparam code_point_t CP_SPACE = 21'h000020;
    localparam code_point_t CP_SLASH = 21'h00002F;
    localparam code_point_t CP_UNDER = 21'h00005F;

    // Character classes
    typedef enum logic [2:0] {
        CLS_CR,
        CLS_LF,
        CLS_WORD,
        CLS_SPACE,
        CLS_SLASH,
        CLS_PUNCT,
        CLS_OTHER
    } char_class_t;

    // Control from the input stage to the tally
    typedef struct packed {
        logic        step;
        logic        is_end;
        char_class_t cls;
    } tally_ctrl_t;

    // The six counts of one text
    typedef struct packed {
        count_t comments;
        count_t code;
        count_t blanks;
        count_t lines;
        count_t words;
        count_t chars;
    } count_set_t;

    // Increment that sticks at the top value
    function automatic count_t sat_inc(count_t v, logic en);
        return (en && (v != CNT_MAX)) ? v + count_t'(1) : v;
    endfunction

    // Counter value saturated to the output field width
    function automatic out_count_t clip_out(count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'(out_count_t'('1))) ? out_count_t'('1) : wide[OUT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/source_text_statistics_counter.sv =====
// Source text statistics counter: one character per cycle, six counts per text.
// An accepted end item is held in the input register; when it steps, its counts go to the result register.
// Throughput: one item per cycle; an end item waits only while an earlier result is untaken.
// Reset (rst_n low, asynchronous) clears all counters, line flags and both valid stages.
// Depends on stsc_pkg, stsc_classify and stsc_tally.
`default_nettype none

module source_text_statistics_counter
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [23:0]   s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  wire [0:0]    s_axis_tuser,   // [0] end_marker
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [191:0] m_axis_tdata    // char_total, word_total, line_total,
                                         // blank_lines, code_lines, comment_lines
                                         // (32 bits each, lowest first)
);

    logic                  in_valid_reg;
    stsc_pkg::code_point_t in_cp_reg;
    logic                  in_end_reg;

    logic                  out_valid_reg;
    logic [191:0]          out_data_reg;

    logic                  advance;
    stsc_pkg::char_class_t cls;
    stsc_pkg::tally_ctrl_t ctrl;
    stsc_pkg::count_set_t  final_counts;

    // An end item may only move on when the result register is free or its result is being taken
    assign advance       = !in_end_reg || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign ctrl.step   = in_valid_reg && advance;
    assign ctrl.is_end = in_end_reg;
    assign ctrl.cls    = cls;

    stsc_classify u_classify
    (
        .code_point (in_cp_reg),
        .cls        (cls)
    );

    stsc_tally u_tally
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .final_counts (final_counts)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cp_reg  <= s_axis_tdata[20:0];
            in_end_reg <= s_axis_tuser[0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.step && in_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && in_end_reg)
        begin
            out_data_reg <= {stsc_pkg::clip_out(final_counts.comments),
                             stsc_pkg::clip_out(final_counts.code),
                             stsc_pkg::clip_out(final_counts.blanks),
                             stsc_pkg::clip_out(final_counts.lines),
                             stsc_pkg::clip_out(final_counts.words),
                             stsc_pkg::clip_out(final_counts.chars)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A held result blocks a following end item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready && in_valid_reg && in_end_reg |-> !ctrl.step)
        else $error("end item overran a waiting result");

    // A stepped end item always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && in_end_reg |=> m_axis_tvalid)
        else $error("end item gave no result");

    // Character items never stall
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_end_reg |-> ctrl.step && s_axis_tready)
        else $error("character item stalled");

endmodule

`default_nettype wire

// ===== sv/stsc_classify.sv =====
// Character classifier: maps one code point to its character class.
// Depends on stsc_pkg.
`default_nettype none

module stsc_classify
(
    input  wire stsc_pkg::code_point_t code_point,
    output stsc_pkg::char_class_t      cls
);

    // Range checks on the code point
    always_comb
    begin
        if (code_point == stsc_pkg::CP_CR)
        begin
            cls = stsc_pkg::CLS_CR;
        end
        else if (code_point == stsc_pkg::CP_LF)
        begin
            cls = stsc_pkg::CLS_LF;
        end
        else if ((code_point >= 21'h30 && code_point <= 21'h39) ||
                 (code_point >= 21'h41 && code_point <= 21'h5A) ||
                 (code_point >= 21'h61 && code_point <= 21'h7A) ||
                 (code_point == stsc_pkg::CP_UNDER))
        begin
            cls = stsc_pkg::CLS_WORD;
        end
        else if (code_point == stsc_pkg::CP_SPACE || code_point == stsc_pkg::CP_TAB)
        begin
            cls = stsc_pkg::CLS_SPACE;
        end
        else if (code_point == stsc_pkg::CP_SLASH)
        begin
            cls = stsc_pkg::CLS_SLASH;
        end
        else if ((code_point >= 21'h21 && code_point <= 21'h2E) ||
                 (code_point >= 21'h3A && code_point <= 21'h40) ||
                 (code_point >= 21'h5B && code_point <= 21'h60) ||
                 (code_point >= 21'h7B && code_point <= 21'h7E))
        begin
            // underscore was caught above as a word character
            cls = stsc_pkg::CLS_PUNCT;
        end
        else
        begin
            cls = stsc_pkg::CLS_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stsc_tally.sv =====
// Counters and per-line flags; updates on every stepped item but a carriage return, hands out final counts.
// Depends on stsc_pkg.
`default_nettype none

module stsc_tally
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire stsc_pkg::tally_ctrl_t ctrl,
    output stsc_pkg::count_set_t       final_counts
);

    stsc_pkg::count_t char_reg, char_next;
    stsc_pkg::count_t word_reg, word_next;
    stsc_pkg::count_t line_reg, line_next;
    stsc_pkg::count_t blank_reg, blank_next;
    stsc_pkg::count_t code_reg, code_next;
    stsc_pkg::count_t comment_reg, comment_next;

    logic visible_reg, visible_next;
    logic word_seen_reg, word_seen_next;
    logic slash_reg, slash_next;
    logic comment_on_reg, comment_on_next;
    logic in_word_reg, in_word_next;

    logic is_comment_line;
    logic is_blank_line;

    // Counts as they stand once the current line is closed
    always_comb
    begin
        is_comment_line = !word_seen_reg && comment_on_reg;
        is_blank_line   = !is_comment_line && !visible_reg;

        final_counts.chars    = char_reg;
        final_counts.words    = stsc_pkg::sat_inc(word_reg, in_word_reg);
        final_counts.lines    = stsc_pkg::sat_inc(line_reg, 1'b1);
        final_counts.comments = stsc_pkg::sat_inc(comment_reg, is_comment_line);
        final_counts.blanks   = stsc_pkg::sat_inc(blank_reg, is_blank_line);
        final_counts.code     = stsc_pkg::sat_inc(code_reg,
                                                  !is_comment_line && !is_blank_line);
    end

    // Next state per character class
    always_comb
    begin
        char_next       = char_reg;
        word_next       = word_reg;
        line_next       = line_reg;
        blank_next      = blank_reg;
        code_next       = code_reg;
        comment_next    = comment_reg;
        visible_next    = visible_reg;
        word_seen_next  = word_seen_reg;
        slash_next      = slash_reg;
        comment_on_next = comment_on_reg;
        in_word_next    = in_word_reg;

        if (ctrl.step)
        begin
            if (ctrl.is_end)
            begin
                // counts go out, everything starts afresh
                char_next       = '0;
                word_next       = '0;
                line_next       = '0;
                blank_next      = '0;
                code_next       = '0;
                comment_next    = '0;
                visible_next    = 1'b0;
                word_seen_next  = 1'b0;
                slash_next      = 1'b0;
                comment_on_next = 1'b0;
                in_word_next    = 1'b0;
            end
            else if (ctrl.cls != stsc_pkg::CLS_CR)
            begin
                char_next = stsc_pkg::sat_inc(char_reg, 1'b1);
                case (ctrl.cls)
                    stsc_pkg::CLS_LF:
                    begin
                        word_next       = final_counts.words;
                        line_next       = final_counts.lines;
                        blank_next      = final_counts.blanks;
                        code_next       = final_counts.code;
                        comment_next    = final_counts.comments;
                        visible_next    = 1'b0;
                        word_seen_next  = 1'b0;
                        slash_next      = 1'b0;
                        comment_on_next = 1'b0;
                        in_word_next    = 1'b0;
                    end
                    stsc_pkg::CLS_WORD:
                    begin
                        if (!comment_on_reg)
                        begin
                            visible_next   = 1'b1;
                            word_seen_next = 1'b1;
                        end
                        slash_next   = 1'b0;
                        in_word_next = 1'b1;
                    end
                    stsc_pkg::CLS_SPACE:
                    begin
                        word_next    = stsc_pkg::sat_inc(word_reg, in_word_reg);
                        slash_next   = 1'b0;
                        in_word_next = 1'b0;
                    end
                    stsc_pkg::CLS_SLASH:
                    begin
                        word_next = stsc_pkg::sat_inc(word_reg, in_word_reg);
                        if (slash_reg)
                        begin
                            comment_on_next = 1'b1;
                        end
                        slash_next   = 1'b1;
                        in_word_next = 1'b0;
                    end
                    stsc_pkg::CLS_PUNCT:
                    begin
                        word_next = stsc_pkg::sat_inc(word_reg, in_word_reg);
                        if (!comment_on_reg)
                        begin
                            visible_next = 1'b1;
                        end
                        slash_next   = 1'b0;
                        in_word_next = 1'b0;
                    end
                    default:
                    begin
                        // any other character is a word of its own; a pending word is dropped
                        word_next    = stsc_pkg::sat_inc(word_reg, 1'b1);
                        slash_next   = 1'b0;
                        in_word_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg       <= '0;
            word_reg       <= '0;
            line_reg       <= '0;
            blank_reg      <= '0;
            code_reg       <= '0;
            comment_reg    <= '0;
            visible_reg    <= 1'b0;
            word_seen_reg  <= 1'b0;
            slash_reg      <= 1'b0;
            comment_on_reg <= 1'b0;
            in_word_reg    <= 1'b0;
        end
        else
        begin
            char_reg       <= char_next;
            word_reg       <= word_next;
            line_reg       <= line_next;
            blank_reg      <= blank_next;
            code_reg       <= code_next;
            comment_reg    <= comment_next;
            visible_reg    <= visible_next;
            word_seen_reg  <= word_seen_next;
            slash_reg      <= slash_next;
            comment_on_reg <= comment_on_next;
            in_word_reg    <= in_word_next;
        end
    end

    // An end item leaves every counter and flag cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && ctrl.is_end |=> char_reg == '0 && line_reg == '0 && word_reg == '0 &&
                                     !in_word_reg && !comment_on_reg && !visible_reg)
        else $error("tally not cleared after end item");

    // A carriage return changes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && !ctrl.is_end && ctrl.cls == stsc_pkg::CLS_CR
        |=> $stable(char_reg) && $stable(word_reg) && $stable(line_reg))
        else $error("carriage return altered counts");

endmodule

`default_nettype wire

// ===== tb/sv/tb_source_text_statistics_counter.sv =====
// Self-checking testbench for source_text_statistics_counter: directed table, then random texts.
// Keeps its own tally of the six counts per text and checks every result item field by field.
// Depends on stsc_pkg and the source_text_statistics_counter RTL.
`timescale 1ns / 100ps

module tb_source_text_statistics_counter;

    // Six counts as they sit in m_axis_tdata, chars in the lowest bits
    typedef struct packed {
        stsc_pkg::out_count_t comments;
        stsc_pkg::out_count_t code;
        stsc_pkg::out_count_t blanks;
        stsc_pkg::out_count_t lines;
        stsc_pkg::out_count_t words;
        stsc_pkg::out_count_t chars;
    } text_counts_t;

    // One row of the directed table
    typedef struct packed {
        stsc_pkg::code_point_t cp;
        logic                  last;
        logic                  typed;
        text_counts_t          want;
    } directed_row_t;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 515;
    localparam int          HOLD_AT     = 110;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 4;
    localparam int          NUM_ROWS    = 24;
    localparam text_counts_t NO_COUNTS  = '0;
    // End of text straight after a clear: one blank line and nothing else
    localparam text_counts_t EMPTY_TEXT =
        {32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0};

    localparam directed_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        {21'h000000,         1'b1, 1'b1, EMPTY_TEXT},  // end marker after reset
        {21'h000000,         1'b0, 1'b0, NO_COUNTS},   // NUL: word by itself
        {21'h000061,         1'b0, 1'b0, NO_COUNTS},   // a
        {21'h00005A,         1'b0, 1'b0, NO_COUNTS},   // Z
        {21'h000039,         1'b0, 1'b0, NO_COUNTS},   // 9
        {stsc_pkg::CP_UNDER, 1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_SPACE, 1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_TAB,   1'b0, 1'b0, NO_COUNTS},
        {21'h000021,         1'b0, 1'b0, NO_COUNTS},   // !
        {stsc_pkg::CP_SLASH, 1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_SLASH, 1'b0, 1'b0, NO_COUNTS},   // opens line comment
        {21'h000078,         1'b0, 1'b0, NO_COUNTS},   // x inside comment
        {stsc_pkg::CP_CR,    1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_LF,    1'b0, 1'b0, NO_COUNTS},
        {21'h00007F,         1'b0, 1'b0, NO_COUNTS},   // DEL: control character
        {21'h10FFFF,         1'b0, 1'b0, NO_COUNTS},   // top of Unicode
        {21'h1FFFFF,         1'b0, 1'b0, NO_COUNTS},   // beyond Unicode, all ones
        {21'h110000,         1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_LF,    1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_SLASH, 1'b0, 1'b0, NO_COUNTS},
        {stsc_pkg::CP_SLASH, 1'b0, 1'b0, NO_COUNTS},   // pure comment line
        {21'h00007E,         1'b0, 1'b0, NO_COUNTS},   // ~ inside comment
        {21'h1FFFFF,         1'b1, 1'b0, NO_COUNTS},   // end marker, code point ignored
        {21'h0AAAAA,         1'b1, 1'b1, EMPTY_TEXT}   // end marker on a cleared block
    };

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;   // [20:0] code_point, [23:21] zero
    logic [0:0]   s_axis_tuser;   // [0] end_marker
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // char, word, line, blank, code, comment totals

    int unsigned  error_count   = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  items_taken   = 0;
    int unsigned  send_idle_pct = 21;
    int unsigned  recv_idle_pct = 67;

    text_counts_t pending_counts[$];

    // Tally state of the text in progress
    stsc_pkg::count_t n_chars   = '0;
    stsc_pkg::count_t n_words   = '0;
    stsc_pkg::count_t n_lines   = '0;
    stsc_pkg::count_t n_blanks  = '0;
    stsc_pkg::count_t n_code    = '0;
    stsc_pkg::count_t n_comment = '0;
    logic   seen_visible  = 1'b0;
    logic   seen_wordchar = 1'b0;
    logic   last_slash    = 1'b0;
    logic   in_comment    = 1'b0;
    logic   word_open     = 1'b0;

    source_text_statistics_counter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic stsc_pkg::count_t bumped(stsc_pkg::count_t v);
        return (v == '1) ? v : v + stsc_pkg::count_t'(1);
    endfunction

    function automatic stsc_pkg::out_count_t clip32(stsc_pkg::count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
    endfunction

    // Letters, digits and underscore
    function automatic logic is_word_char(stsc_pkg::code_point_t c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
               (c >= 21'h30 && c <= 21'h39) || c == stsc_pkg::CP_UNDER;
    endfunction

    // Punctuation is printable ASCII that is neither word character nor slash
    function automatic logic is_punct(stsc_pkg::code_point_t c);
        return c >= 21'h21 && c <= 21'h7E && !is_word_char(c) && c != stsc_pkg::CP_SLASH;
    endfunction

    function automatic void close_text_line();
        n_lines = bumped(n_lines);
        if (word_open)
            n_words = bumped(n_words);
        if (in_comment && !seen_wordchar)
            n_comment = bumped(n_comment);
        else if (!seen_visible)
            n_blanks = bumped(n_blanks);
        else
            n_code = bumped(n_code);
        seen_visible  = 1'b0;
        seen_wordchar = 1'b0;
        last_slash    = 1'b0;
        in_comment    = 1'b0;
        word_open     = 1'b0;
    endfunction

    // Advances the tally by one item; returns 1 with the counts on an end marker
    function automatic logic text_step(input stsc_pkg::code_point_t cp, input logic last,
                                       output text_counts_t counts);
        counts = '0;
        if (last)
        begin
            close_text_line();
            counts.chars    = clip32(n_chars);
            counts.words    = clip32(n_words);
            counts.lines    = clip32(n_lines);
            counts.blanks   = clip32(n_blanks);
            counts.code     = clip32(n_code);
            counts.comments = clip32(n_comment);
            n_chars   = '0;
            n_words   = '0;
            n_lines   = '0;
            n_blanks  = '0;
            n_code    = '0;
            n_comment = '0;
            return 1'b1;
        end
        if (cp == stsc_pkg::CP_CR)
            return 1'b0;
        n_chars = bumped(n_chars);
        if (cp == stsc_pkg::CP_LF)
            close_text_line();
        else if (is_word_char(cp))
        begin
            if (!in_comment)
            begin
                seen_visible  = 1'b1;
                seen_wordchar = 1'b1;
            end
            last_slash = 1'b0;
            word_open  = 1'b1;
        end
        else if (cp == stsc_pkg::CP_SPACE || cp == stsc_pkg::CP_TAB)
        begin
            if (word_open)
                n_words = bumped(n_words);
            last_slash = 1'b0;
            word_open  = 1'b0;
        end
        else if (cp == stsc_pkg::CP_SLASH)
        begin
            if (word_open)
                n_words = bumped(n_words);
            if (last_slash)
                in_comment = 1'b1;
            last_slash = 1'b1;
            word_open  = 1'b0;
        end
        else if (is_punct(cp))
        begin
            if (word_open)
                n_words = bumped(n_words);
            if (!in_comment)
                seen_visible = 1'b1;
            last_slash = 1'b0;
            word_open  = 1'b0;
        end
        else
        begin
            // anything else is a word on its own
            n_words    = bumped(n_words);
            last_slash = 1'b0;
            word_open  = 1'b0;
        end
        return 1'b0;
    endfunction

    // Character drawn with a bias towards source-like text
    function automatic stsc_pkg::code_point_t random_char();
        int unsigned pick;
        stsc_pkg::code_point_t cp;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            cp = stsc_pkg::code_point_t'($urandom_range(21'h61, 21'h7A));   // a..z
        else if (pick < 22)
            cp = stsc_pkg::code_point_t'($urandom_range(21'h41, 21'h5A));   // A..Z
        else if (pick < 28)
            cp = stsc_pkg::code_point_t'($urandom_range(21'h30, 21'h39));   // 0..9
        else if (pick < 31)
            cp = stsc_pkg::CP_UNDER;
        else if (pick < 43)
            cp = stsc_pkg::CP_SPACE;
        else if (pick < 46)
            cp = stsc_pkg::CP_TAB;
        else if (pick < 58)
            cp = stsc_pkg::CP_SLASH;
        else if (pick < 70)
        begin
            cp = stsc_pkg::code_point_t'($urandom_range(33, 126));
            while (!is_punct(cp))
                cp = stsc_pkg::code_point_t'($urandom_range(33, 126));
        end
        else if (pick < 80)
            cp = stsc_pkg::CP_LF;
        else if (pick < 84)
            cp = stsc_pkg::CP_CR;
        else if (pick < 88)
        begin
            cp = stsc_pkg::code_point_t'($urandom_range(0, 31));
            if (cp == stsc_pkg::CP_TAB || cp == stsc_pkg::CP_LF || cp == stsc_pkg::CP_CR)
                cp = 21'h7F;
        end
        else if (pick < 94)
            cp = stsc_pkg::code_point_t'($urandom_range(21'h80, 21'h10FFFF));
        else
            cp = stsc_pkg::code_point_t'($urandom_range(0, 21'h1FFFFF));
        return cp;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input stsc_pkg::out_count_t got,
                               input stsc_pkg::out_count_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Offers one item from a falling edge and returns at the falling edge after acceptance
    task automatic push_item(input stsc_pkg::code_point_t cp, input logic last,
                             input logic use_typed, input text_counts_t typed_counts);
        text_counts_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, cp};
        s_axis_tuser  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_taken++;
        if (text_step(cp, last, predicted))
            pending_counts.push_back(use_typed ? typed_counts : predicted);
        @(negedge clk);
    endtask

    // A text of random length closed by an end marker, now and then pure noise
    task automatic send_text();
        int unsigned len;
        if ($urandom_range(0, 11) == 0)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
                push_item(stsc_pkg::code_point_t'($urandom_range(0, 21'h1FFFFF)),
                          ($urandom_range(0, 1) != 0), 1'b0, NO_COUNTS);
        end
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 40);
            repeat (len)
                push_item(random_char(), 1'b0, 1'b0, NO_COUNTS);
            push_item(stsc_pkg::code_point_t'($urandom_range(0, 21'h1FFFFF)), 1'b1,
                      1'b0, NO_COUNTS);
        end
    endtask

    // Result side: random stalls plus one long hold-off
    initial
    begin
        int unsigned hold_left;
        logic        hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker and run limit
    always @(posedge clk)
    begin
        text_counts_t got;
        text_counts_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** source_text_statistics_counter: FAILED **");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_counts.size() == 0)
                report_mismatch("result item with no text closed");
            else
            begin
                want = pending_counts.pop_front();
                check_field("char_total",    got.chars,    want.chars);
                check_field("word_total",    got.words,    want.words);
                check_field("line_total",    got.lines,    want.lines);
                check_field("blank_lines",   got.blanks,   want.blanks);
                check_field("code_lines",    got.code,     want.code);
                check_field("comment_lines", got.comments, want.comments);
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned phase_start;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int row = 0; row < NUM_ROWS; row++)
            push_item(DIRECTED_ROWS[row].cp, DIRECTED_ROWS[row].last,
                      DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);

        // random texts in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = items_taken;
            while (items_taken - phase_start < PHASE_ITEMS)
                send_text();
        end
        s_axis_tvalid = 1'b0;

        // drain outstanding results
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (error_count == 0)
            $display("** source_text_statistics_counter: PASSED **");
        else
            $display("** source_text_statistics_counter: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/stsc_pkg.sv
sv/stsc_classify.sv
sv/stsc_tally.sv
sv/source_text_statistics_counter.sv
tb/sv/tb_source_text_statistics_counter.sv
